// ===== rtl/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types, byte codes and result helpers of the request head tokenizer.
// ----------------------------------------------------------------------------
package hrt_pkg;

   localparam int MaxHeadersDefault = 12;
   localparam int RspDepth          = 4;

   localparam logic [7:0] ByteCr    = 8'h0d;
   localparam logic [7:0] ByteLf    = 8'h0a;
   localparam logic [7:0] ByteSp    = 8'h20;
   localparam logic [7:0] ByteColon = 8'h3a;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_URL     = 3'd1,
      PH_VERSION = 3'd2,
      PH_KEY     = 3'd3,
      PH_VALUE   = 3'd4,
      PH_ERROR   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_CR    = 2'd1,
      HOLD_COLON = 2'd2
   } hold_type;

   typedef enum logic [2:0] {
      KIND_DATA    = 3'd0,
      KIND_END     = 3'd1,
      KIND_DISCARD = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type  phase;
      hold_type   held;
      logic       line_empty;
   } ctrl_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] field_class;
      logic [7:0] data_byte;
      logic [3:0] header_index;
      logic       last;
   } result_type;

   typedef struct packed {
      result_type r0;
      result_type r1;
      logic [1:0] count;
   } pair_type;

   function automatic result_type make_result(kind_type kind, logic [2:0] field_class,
                                              logic [7:0] data_byte,
                                              logic [3:0] header_index);
      result_type r;
      r.kind         = kind;
      r.field_class  = field_class;
      r.data_byte    = data_byte;
      r.header_index = header_index;
      r.last         = 1'b1;
      return r;
   endfunction

   // append one result; the newest carries the last flag
   function automatic pair_type put(pair_type p, result_type r);
      pair_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.r0    = r;
         q.count = 2'd1;
      end else if (p.count == 2'd1) begin
         q.r0.last = 1'b0;
         q.r1      = r;
         q.count   = 2'd2;
      end
      return q;
   endfunction

endpackage

// ===== rtl/hrt_step.sv =====
// ----------------------------------------------------------------------------
// hrt_step
// Next state and up to two results for one request byte.
// ----------------------------------------------------------------------------
module hrt_step #(
   parameter int MAX_HEADERS = hrt_pkg::MaxHeadersDefault,
   parameter int CntW        = $clog2(MAX_HEADERS + 1)
) (
   input  hrt_pkg::ctrl_type   ctrl,
   input  logic [CntW-1:0]     hdr_count,
   input  logic [7:0]          in_byte,
   output hrt_pkg::ctrl_type   ctrl_nxt,
   output logic [CntW-1:0]     hdr_count_nxt,
   output hrt_pkg::pair_type   results
);

   always_comb begin
      hrt_pkg::phase_type ph;
      hrt_pkg::hold_type  hd;
      logic               le;
      logic [CntW-1:0]    hc;
      logic [CntW+3:0]    hc_ext;
      logic [3:0]         idx;
      logic               run_byte;
      logic               do_crlf;
      hrt_pkg::pair_type  p;

      ph       = ctrl.phase;
      hd       = ctrl.held;
      le       = ctrl.line_empty;
      hc       = hdr_count;
      hc_ext   = {4'b0000, hc};
      idx      = 4'd0;
      run_byte = 1'b0;
      do_crlf  = 1'b0;
      p        = '0;

      if (ph == hrt_pkg::PH_ERROR) begin
         p = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_ERROR, 3'd0, 8'd0, 4'd0));
      end else if (hd == hrt_pkg::HOLD_CR) begin
         hd = hrt_pkg::HOLD_NONE;
         if (in_byte == hrt_pkg::ByteLf) begin
            do_crlf = 1'b1;
         end else begin
            idx = (ph == hrt_pkg::PH_KEY || ph == hrt_pkg::PH_VALUE) ? hc_ext[3:0] : 4'd0;
            if (ph == hrt_pkg::PH_KEY) begin
               le = 1'b0;
            end
            p = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_DATA, ph,
                                                     hrt_pkg::ByteCr, idx));
            run_byte = 1'b1;
         end
      end else if (hd == hrt_pkg::HOLD_COLON && ph == hrt_pkg::PH_KEY) begin
         hd = hrt_pkg::HOLD_NONE;
         if (in_byte == hrt_pkg::ByteSp) begin
            if (hc >= CntW'(MAX_HEADERS)) begin
               ph = hrt_pkg::PH_ERROR;
               p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_ERROR, 3'd0,
                                                         8'd0, 4'd0));
            end else begin
               p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_END,
                                                         hrt_pkg::PH_KEY, 8'd0,
                                                         hc_ext[3:0]));
               ph = hrt_pkg::PH_VALUE;
            end
         end else begin
            le = 1'b0;
            p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_DATA, hrt_pkg::PH_KEY,
                                                      hrt_pkg::ByteColon, hc_ext[3:0]));
            run_byte = 1'b1;
         end
      end else begin
         hd       = hrt_pkg::HOLD_NONE;
         run_byte = 1'b1;
      end

      if (do_crlf) begin
         unique case (ph)
            hrt_pkg::PH_METHOD, hrt_pkg::PH_URL: begin
               ph = hrt_pkg::PH_ERROR;
               p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_ERROR, 3'd0,
                                                         8'd0, 4'd0));
            end
            hrt_pkg::PH_VERSION: begin
               p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_END,
                                                         hrt_pkg::PH_VERSION, 8'd0, 4'd0));
               ph = hrt_pkg::PH_KEY;
               le = 1'b1;
            end
            hrt_pkg::PH_KEY: begin
               if (!le) begin
                  p = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_DISCARD,
                                                           hrt_pkg::PH_KEY, 8'd0,
                                                           hc_ext[3:0]));
               end
               p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_DONE, 3'd0,
                                                         8'd0, 4'd0));
               ph = hrt_pkg::PH_METHOD;
               hc = '0;
               le = 1'b1;
            end
            default: begin
               p = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_END,
                                                        hrt_pkg::PH_VALUE, 8'd0,
                                                        hc_ext[3:0]));
               if (hc < CntW'(MAX_HEADERS)) begin
                  hc = hc + CntW'(1);
               end
               ph = hrt_pkg::PH_KEY;
               le = 1'b1;
            end
         endcase
      end

      if (run_byte) begin
         idx = (ph == hrt_pkg::PH_KEY || ph == hrt_pkg::PH_VALUE) ? hc_ext[3:0] : 4'd0;
         if ((ph == hrt_pkg::PH_METHOD || ph == hrt_pkg::PH_URL)
             && in_byte == hrt_pkg::ByteSp) begin
            p  = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_END, ph, 8'd0, 4'd0));
            ph = (ph == hrt_pkg::PH_METHOD) ? hrt_pkg::PH_URL : hrt_pkg::PH_VERSION;
         end else if (ph == hrt_pkg::PH_KEY && in_byte == hrt_pkg::ByteColon) begin
            hd = hrt_pkg::HOLD_COLON;
         end else if (in_byte == hrt_pkg::ByteCr) begin
            hd = hrt_pkg::HOLD_CR;
         end else begin
            if (ph == hrt_pkg::PH_KEY) begin
               le = 1'b0;
            end
            p = hrt_pkg::put(p, hrt_pkg::make_result(hrt_pkg::KIND_DATA, ph, in_byte, idx));
         end
      end

      if (ph == hrt_pkg::PH_ERROR) begin
         hd = hrt_pkg::HOLD_NONE;
      end

      ctrl_nxt.phase      = ph;
      ctrl_nxt.held       = hd;
      ctrl_nxt.line_empty = le;
      hdr_count_nxt       = hc;
      results             = p;
   end

endmodule

// ===== rtl/hrt_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// hrt_rsp_fifo
// Result queue: takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module hrt_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  hrt_pkg::pair_type   push,
   input  logic                push_en,
   input  logic                pop,
   output hrt_pkg::result_type head,
   output logic                not_empty,
   output logic                room_for_two,
   output logic [2:0]          level
);

   localparam int PtrW = $clog2(hrt_pkg::RspDepth);
   localparam int LvlW = $clog2(hrt_pkg::RspDepth + 1);

   hrt_pkg::result_type mem [hrt_pkg::RspDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]     cnt_ff, cnt_in;
   logic [1:0]          push_n;

   assign push_n = push_en ? push.count : 2'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      cnt_in    = cnt_ff + LvlW'(push_n) - LvlW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem[wr_ptr_ff] <= push.r0;
      end
      if (push_n == 2'd2) begin
         mem[wr_ptr_ff + PtrW'(1)] <= push.r1;
      end
   end

   assign head         = mem[rd_ptr_ff];
   assign not_empty    = (cnt_ff != '0);
   assign room_for_two = (cnt_ff <= LvlW'(hrt_pkg::RspDepth - 2));
   assign level        = 3'(cnt_ff);

endmodule

// ===== rtl/http_request_head_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_request_head_tokenizer
// Tags each request byte by field and marks field ends and head completion.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while the result queue has room for two
// results. A byte sits in the input register while the phase logic classifies
// it, then its zero, one or two results go into a four-entry result queue
// that drives the rsp_ ports. A byte with two results (a CR or colon released
// before data, or a key discard before head done) fills two entries, so the
// result port's one result per cycle, while rsp_ready is high, sets the rate.
module http_request_head_tokenizer #(
   parameter int MAX_HEADERS = hrt_pkg::MaxHeadersDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_result_kind,
   output logic [2:0] rsp_field_class,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_header_index,
   output logic       rsp_last_of_run
);

   localparam int CntW = $clog2(MAX_HEADERS + 1);

   logic              in_vld_ff, in_vld_in;
   logic [7:0]        in_byte_ff;
   hrt_pkg::ctrl_type ctrl_ff, ctrl_in;
   logic [CntW-1:0]   count_ff, count_in;
   hrt_pkg::pair_type results;
   hrt_pkg::result_type head;
   logic              advance;
   logic              room_for_two;
   logic [2:0]        level;

   hrt_step #(
      .MAX_HEADERS (MAX_HEADERS),
      .CntW        (CntW)
   ) u_step (
      .ctrl          (ctrl_ff),
      .hdr_count     (count_ff),
      .in_byte       (in_byte_ff),
      .ctrl_nxt      (ctrl_in),
      .hdr_count_nxt (count_in),
      .results       (results)
   );

   hrt_rsp_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (results),
      .push_en      (advance),
      .pop          (rsp_valid & rsp_ready),
      .head         (head),
      .not_empty    (rsp_valid),
      .room_for_two (room_for_two),
      .level        (level)
   );

   assign advance   = in_vld_ff & room_for_two;
   assign req_ready = ~in_vld_ff | advance;
   assign in_vld_in = (req_valid & req_ready) | (in_vld_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff           <= 1'b0;
         ctrl_ff.phase       <= hrt_pkg::PH_METHOD;
         ctrl_ff.held        <= hrt_pkg::HOLD_NONE;
         ctrl_ff.line_empty  <= 1'b1;
         count_ff            <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (advance) begin
            ctrl_ff  <= ctrl_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   assign rsp_result_kind  = head.kind;
   assign rsp_field_class  = head.field_class;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_header_index = head.header_index;
   assign rsp_last_of_run  = head.last;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= 3'(hrt_pkg::RspDepth))
      else $error("result queue overfilled");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_vld_ff && !room_for_two)
      else $error("input stalled with room in result queue");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.phase == hrt_pkg::PH_ERROR |=> ctrl_ff.phase == hrt_pkg::PH_ERROR)
      else $error("error phase left without reset");

   a_data_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != hrt_pkg::KIND_DATA |-> rsp_data_byte == 8'd0)
      else $error("byte on non-data result");
`endif

endmodule
